// File: rtl/core/pdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_pkg: point deduplication table package
// Shared widths, constants and the token that walks the compare chain.
// ----------------------------------------------------------------------------
package pdt_pkg;

    localparam int PDT_MAX_POINTS = 256;
    localparam int COORD_W        = 32;
    localparam int TOL_W          = 10;
    localparam int INDEX_W        = 8;
    localparam int COUNT_W        = 8;
    localparam int PADDR_W        = 2;
    localparam int PDATA_W        = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Token carried from cell to cell: the point under search and,
    // once a cell has claimed it, the result for that point.
    typedef struct packed {
        logic                       valid;
        logic                       done;
        logic                       is_new;
        logic [INDEX_W-1:0]         index;
        logic [COUNT_W-1:0]         count;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } pdt_token_t;

endpackage

// File: rtl/core/pdt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_ifs: stream interfaces of the point deduplication table
// Point input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdt_point_if
    import pdt_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface pdt_result_if
    import pdt_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] unique_index;
    logic               is_new;
    logic [COUNT_W-1:0] hit_count;
    logic               table_full;

    modport source (output valid, output unique_index, output is_new,
                    output hit_count, output table_full, input ready);
    modport sink   (input valid, input unique_index, input is_new,
                    input hit_count, input table_full, output ready);
endinterface

// File: rtl/core/point_dedup_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_dedup_table_top: tolerance-matching deduplication table
// Systolic chain of entry cells that merges near-identical 3D points.
// ----------------------------------------------------------------------------
// Each accepted point walks a chain of MAX_POINTS cells, one cell per cycle
// while the chain advances, and its result is registered after the last cell.
// A new point may be accepted every cycle unless the chain holds; points follow
// one another down the chain, so each sees every update made by those before
// it. The first valid cell within the tolerance on all three axes takes the
// point and bumps its count (held at 255); otherwise the first empty cell
// stores it. A point that reaches the end unclaimed gives a table-full result.
// When a result beat is not taken the whole chain holds. Entry valid bits clear
// at reset, so there is no clearing pass.
module point_dedup_table_top
    import pdt_pkg::*;
#(
    parameter int MAX_POINTS = PDT_MAX_POINTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    pdt_point_if.sink          pt,
    pdt_result_if.source       res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [TOL_W-1:0]     tol;
    logic                 adv;
    pdt_token_t           head;
    pdt_token_t           chain [MAX_POINTS+1];
    logic [MAX_POINTS-1:0] used_vec;

    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic                 out_new_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_full_reg;
    pdt_token_t           last;

    pdt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tol     (tol)
    );

    // The chain moves whenever the result register is free or being emptied.
    assign adv      = !out_valid_reg || res.ready;
    assign pt.ready = adv;

    always_comb
    begin
        head        = '0;
        head.valid  = pt.valid;
        head.x      = pt.point_x;
        head.y      = pt.point_y;
        head.z      = pt.point_z;
    end

    assign chain[0] = head;

    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_cell
        pdt_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .tol         (tol),
            .tok_in      (chain[k]),
            .tok_out     (chain[k+1]),
            .entry_valid (used_vec[k])
        );
    end

    assign last = chain[MAX_POINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (last.done)
            begin
                out_index_reg <= last.index;
                out_new_reg   <= last.is_new;
                out_count_reg <= last.count;
                out_full_reg  <= 1'b0;
            end
            else
            begin
                out_index_reg <= '0;
                out_new_reg   <= 1'b0;
                out_count_reg <= '0;
                out_full_reg  <= 1'b1;
            end
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.unique_index = out_index_reg;
    assign res.is_new       = out_new_reg;
    assign res.hit_count    = out_count_reg;
    assign res.table_full   = out_full_reg;

`ifndef SYNTH
    // Entries fill from the bottom up, so the valid bits form one solid run.
    a_used_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, used_vec} + {{MAX_POINTS{1'b0}}, 1'b1}))
        else $error("entry valid bits are not contiguous");

    a_new_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.is_new) |-> (res.hit_count == COUNT_W'(1) && !res.table_full))
        else $error("new entry beat without count of one");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.table_full) |-> (used_vec[MAX_POINTS-1] && res.unique_index == '0
                                           && res.hit_count == '0))
        else $error("table full beat while table has room or with payload");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.table_full) |-> (res.hit_count != '0))
        else $error("matched beat with zero count");
`endif

endmodule

// File: rtl/core/pdt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_cfg: configuration register block
// APB-style slave holding the match tolerance register.
// ----------------------------------------------------------------------------
module pdt_cfg
    import pdt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [TOL_W-1:0]   tol
);

    logic [TOL_W-1:0] tol_reg;
    logic             wr_en;

    // The map holds one word, so every byte address falls on the tolerance register.
    assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1:0] == paddr);
    assign pready = 1'b1;
    assign prdata = {{(PDATA_W-TOL_W){1'b0}}, tol_reg};
    assign tol    = tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (wr_en)
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

endmodule

// File: rtl/core/pdt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_cell: one table entry with its compare stage
// Holds one unique point and its count, and forwards the search token.
// ----------------------------------------------------------------------------
module pdt_cell
    import pdt_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [TOL_W-1:0] tol,
    input  pdt_token_t       tok_in,
    output pdt_token_t       tok_out,
    output logic             entry_valid
);

    logic                      entry_valid_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic signed [COORD_W-1:0] sx_reg;
    logic signed [COORD_W-1:0] sy_reg;
    logic signed [COORD_W-1:0] sz_reg;
    logic                      tok_valid_reg;
    pdt_token_t                tok_reg;
    pdt_token_t                tok_next;
    logic                      searching;
    logic                      hit;
    logic                      claim;

    // Differences are taken one bit wider so that they never wrap.
    function automatic logic near(input logic signed [COORD_W-1:0] a,
                                  input logic signed [COORD_W-1:0] b,
                                  input logic [TOL_W-1:0] t);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        mag;
        d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        mag = d[COORD_W] ? -d : d;
        return mag <= {{(COORD_W+1-TOL_W){1'b0}}, t};
    endfunction

    assign searching = tok_in.valid && !tok_in.done;
    assign hit       = searching && entry_valid_reg
                       && near(tok_in.x, sx_reg, tol)
                       && near(tok_in.y, sy_reg, tol)
                       && near(tok_in.z, sz_reg, tol);
    assign claim     = searching && !entry_valid_reg;

    always_comb
    begin
        count_next = count_reg;
        tok_next   = tok_in;
        if (hit)
        begin
            count_next     = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
            tok_next.done  = 1'b1;
            tok_next.is_new = 1'b0;
            tok_next.index = INDEX_W'(CELL_IDX);
            tok_next.count = count_next;
        end
        else if (claim)
        begin
            count_next      = COUNT_W'(1);
            tok_next.done   = 1'b1;
            tok_next.is_new = 1'b1;
            tok_next.index  = INDEX_W'(CELL_IDX);
            tok_next.count  = COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            count_reg       <= '0;
            tok_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            count_reg     <= count_next;
            tok_valid_reg <= tok_next.valid;
            if (claim)
            begin
                entry_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
            if (claim)
            begin
                sx_reg <= tok_in.x;
                sy_reg <= tok_in.y;
                sz_reg <= tok_in.z;
            end
        end
    end

    // The valid bit comes from the reset flop; the rest of the token needs no reset.
    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

    assign entry_valid = entry_valid_reg;

endmodule
